>>> rtl/generational_handle_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Generational handle allocator assertion macros
// Concurrent assertion shorthands on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define GHA_ASSERT_IMPLY(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("handle allocator assertion failed");

// next-cycle implication
`define GHA_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("handle allocator assertion failed");

// delayed implication
`define GHA_ASSERT_DELAY2(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> ##2 (b)) \
        else $error("handle allocator assertion failed");

`endif

>>> rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Field widths, opcodes, status codes, controller types and defaults.
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 10;
    localparam int GEN_W    = 16;
    localparam int STATUS_W = 2;

    localparam int SLOT_COUNT_DEF      = 1024;
    localparam int GENERATION_BITS_DEF = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CREATE = 3'd0,
        OP_FREE   = 3'd1,
        OP_CHECK  = 3'd2,
        OP_GET    = 3'd3,
        OP_CLEAR  = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_FULL          = 2'd1,
        ST_GEN_EXHAUSTED = 2'd2,
        ST_OUT_OF_RANGE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
        logic link;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic need_link;
    } t_stat;

endpackage

>>> rtl/gha_if.sv
// ----------------------------------------------------------------------------
// Generational handle allocator channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gha_in_if;
    logic                         valid;
    logic                         ready;
    logic [gha_pkg::OPCODE_W-1:0] opcode;
    logic [gha_pkg::INDEX_W-1:0]  handle_index;
    logic [gha_pkg::GEN_W-1:0]    handle_generation;

    modport source (output valid, opcode, handle_index, handle_generation, input ready);
    modport sink   (input valid, opcode, handle_index, handle_generation, output ready);
endinterface

interface gha_out_if;
    logic                         valid;
    logic                         ready;
    logic [gha_pkg::INDEX_W-1:0]  result_index;
    logic [gha_pkg::GEN_W-1:0]    result_generation;
    logic                         handle_ok;
    logic [gha_pkg::STATUS_W-1:0] status;

    modport source (output valid, result_index, result_generation, handle_ok, status,
                    input ready);
    modport sink   (input valid, result_index, result_generation, handle_ok, status,
                    output ready);
endinterface

>>> rtl/gha_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/gha_ctrl.sv
// ----------------------------------------------------------------------------
// Generational handle allocator controller
// Sequences capture, execute and tail-link steps of one request word.
// ----------------------------------------------------------------------------
module gha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  gha_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output gha_pkg::t_cmd  o_cmd
);

    gha_pkg::t_state r_state;
    gha_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gha_pkg::S_IDLE: begin
                if (i_in_valid && i_stat.out_free) begin
                    n_state = gha_pkg::S_EXEC;
                end
            end
            gha_pkg::S_EXEC: begin
                n_state = i_stat.need_link ? gha_pkg::S_LINK : gha_pkg::S_IDLE;
            end
            gha_pkg::S_LINK: begin
                n_state = gha_pkg::S_IDLE;
            end
            default: begin
                n_state = gha_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        o_cmd.link    = 1'b0;
        unique case (r_state)
            gha_pkg::S_IDLE: begin
                o_in_ready    = i_stat.out_free;
                o_cmd.capture = i_in_valid && i_stat.out_free;
            end
            gha_pkg::S_EXEC: begin
                o_cmd.execute = 1'b1;
            end
            gha_pkg::S_LINK: begin
                o_cmd.link = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/gha_datapath.sv
// ----------------------------------------------------------------------------
// Generational handle allocator datapath
// Slot tables, free list pointers, table size and the result register.
// ----------------------------------------------------------------------------
module gha_datapath #(
    parameter int SLOT_COUNT      = gha_pkg::SLOT_COUNT_DEF,
    parameter int GENERATION_BITS = gha_pkg::GENERATION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gha_pkg::t_cmd                i_cmd,
    output gha_pkg::t_stat               o_stat,
    input  logic [gha_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [gha_pkg::INDEX_W-1:0]  i_handle_index,
    input  logic [gha_pkg::GEN_W-1:0]    i_handle_generation,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [gha_pkg::INDEX_W-1:0]  o_result_index,
    output logic [gha_pkg::GEN_W-1:0]    o_result_generation,
    output logic                         o_handle_ok,
    output logic [gha_pkg::STATUS_W-1:0] o_status
);

    localparam int IW   = $clog2(SLOT_COUNT);
    localparam int CNTW = $clog2(SLOT_COUNT + 1);
    localparam int GW   = GENERATION_BITS;
    localparam int MW   = IW + 2;
    localparam int RW   = (CNTW > gha_pkg::INDEX_W) ? CNTW : gha_pkg::INDEX_W;
    localparam int CW   = (GW > gha_pkg::GEN_W) ? GW : gha_pkg::GEN_W;
    localparam int M_USED  = IW + 1;
    localparam int M_VALID = IW;
    localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(SLOT_COUNT);
    localparam logic [GW-1:0]   GEN_MAX    = {GW{1'b1}};

    // request capture
    logic [gha_pkg::OPCODE_W-1:0] r_op;
    logic [gha_pkg::INDEX_W-1:0]  r_idx;
    logic [gha_pkg::GEN_W-1:0]    r_gen_in;

    // free list and table size
    logic [IW-1:0]   r_head, n_head;
    logic [IW-1:0]   r_tail, n_tail;
    logic            r_nonempty, n_nonempty;
    logic [CNTW-1:0] r_count, n_count;

    // result register
    logic                         r_out_valid, n_out_valid;
    logic [gha_pkg::INDEX_W-1:0]  r_res_index, n_res_index;
    logic [gha_pkg::GEN_W-1:0]    r_res_gen, n_res_gen;
    logic                         r_res_ok, n_res_ok;
    logic [gha_pkg::STATUS_W-1:0] r_res_status, n_res_status;

    // memory ports
    logic          gen_we, meta_we, rd_en;
    logic [IW-1:0] gen_waddr, meta_waddr, rd_addr;
    logic [GW-1:0] gen_wdata, gen_rdata, gen_inc;
    logic [MW-1:0] meta_wdata, meta_rdata;

    logic [IW-1:0] idx_slot;
    logic          in_range;
    logic          check_ok;

    assign idx_slot = IW'(r_idx);
    assign in_range = RW'(r_idx) < RW'(r_count);
    assign gen_inc  = GW'(gen_rdata + 1'b1);
    assign check_ok = (r_gen_in != '0) && meta_rdata[M_USED]
                      && (CW'(gen_rdata) == CW'(r_gen_in));

    assign rd_en   = i_cmd.capture;
    assign rd_addr = (i_opcode == gha_pkg::OP_CREATE) ? r_head : IW'(i_handle_index);

    gha_ram #(
        .WIDTH (GW),
        .DEPTH (SLOT_COUNT)
    ) u_gen_ram (
        .i_clk     (i_clk),
        .i_wr_en   (gen_we),
        .i_wr_addr (gen_waddr),
        .i_wr_data (gen_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (gen_rdata)
    );

    gha_ram #(
        .WIDTH (MW),
        .DEPTH (SLOT_COUNT)
    ) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (meta_we),
        .i_wr_addr (meta_waddr),
        .i_wr_data (meta_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (meta_rdata)
    );

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_nonempty   = r_nonempty;
        n_count      = r_count;
        n_res_index  = r_res_index;
        n_res_gen    = r_res_gen;
        n_res_ok     = r_res_ok;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        gen_we       = 1'b0;
        gen_waddr    = r_head;
        gen_wdata    = gen_inc;
        meta_we      = 1'b0;
        meta_waddr   = r_head;
        meta_wdata   = '0;

        if (i_cmd.execute) begin
            n_out_valid  = 1'b1;
            n_res_index  = '0;
            n_res_gen    = '0;
            n_res_ok     = 1'b0;
            n_res_status = gha_pkg::ST_OK;
            unique case (r_op)
                gha_pkg::OP_CREATE: begin
                    if (r_nonempty) begin
                        // pop the head slot
                        if (meta_rdata[M_VALID]) begin
                            n_head = meta_rdata[IW-1:0];
                        end else begin
                            n_nonempty = 1'b0;
                            n_head     = '0;
                            n_tail     = '0;
                        end
                        meta_we     = 1'b1;
                        meta_waddr  = r_head;
                        n_res_index = gha_pkg::INDEX_W'(r_head);
                        if (gen_rdata == GEN_MAX) begin
                            meta_wdata   = {1'b0, 1'b0, {IW{1'b0}}};
                            n_res_status = gha_pkg::ST_GEN_EXHAUSTED;
                        end else begin
                            meta_wdata = {1'b1, 1'b0, {IW{1'b0}}};
                            gen_we     = 1'b1;
                            gen_waddr  = r_head;
                            gen_wdata  = gen_inc;
                            n_res_gen  = gha_pkg::GEN_W'(gen_inc);
                        end
                    end else if (r_count < FULL_COUNT) begin
                        // fresh slot, generation starts at one
                        n_count     = CNTW'(r_count + 1'b1);
                        gen_we      = 1'b1;
                        gen_waddr   = r_count[IW-1:0];
                        gen_wdata   = GW'(1);
                        meta_we     = 1'b1;
                        meta_waddr  = r_count[IW-1:0];
                        meta_wdata  = {1'b1, 1'b0, {IW{1'b0}}};
                        n_res_index = gha_pkg::INDEX_W'(r_count[IW-1:0]);
                        n_res_gen   = gha_pkg::GEN_W'(1);
                    end else begin
                        n_res_status = gha_pkg::ST_FULL;
                    end
                end
                gha_pkg::OP_FREE: begin
                    n_res_index = r_idx;
                    if (in_range) begin
                        meta_we    = 1'b1;
                        meta_waddr = idx_slot;
                        meta_wdata = {1'b0, 1'b0, {IW{1'b0}}};
                        if (!r_nonempty) begin
                            n_head     = idx_slot;
                            n_tail     = idx_slot;
                            n_nonempty = 1'b1;
                        end
                    end else begin
                        n_res_status = gha_pkg::ST_OUT_OF_RANGE;
                    end
                end
                gha_pkg::OP_CHECK: begin
                    n_res_index = r_idx;
                    if (in_range) begin
                        n_res_ok = check_ok;
                    end else begin
                        n_res_status = gha_pkg::ST_OUT_OF_RANGE;
                    end
                end
                gha_pkg::OP_GET: begin
                    if (in_range) begin
                        n_res_index = r_idx;
                        n_res_gen   = gha_pkg::GEN_W'(gen_rdata);
                        n_res_ok    = 1'b1;
                    end else begin
                        n_res_status = gha_pkg::ST_OUT_OF_RANGE;
                    end
                end
                gha_pkg::OP_CLEAR: begin
                    n_head     = '0;
                    n_tail     = '0;
                    n_nonempty = 1'b0;
                    n_count    = '0;
                end
                default: begin
                    n_res_status = gha_pkg::ST_OK;
                end
            endcase
        end

        if (i_cmd.link) begin
            // append behind the old tail
            meta_we    = 1'b1;
            meta_waddr = r_tail;
            meta_wdata = {1'b0, 1'b1, idx_slot};
            n_tail     = idx_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_nonempty  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_nonempty  <= n_nonempty;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_idx    <= i_handle_index;
            r_gen_in <= i_handle_generation;
        end
        r_res_index  <= n_res_index;
        r_res_gen    <= n_res_gen;
        r_res_ok     <= n_res_ok;
        r_res_status <= n_res_status;
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.need_link = (r_op == gha_pkg::OP_FREE) && in_range && r_nonempty;

    assign o_out_valid         = r_out_valid;
    assign o_result_index      = r_res_index;
    assign o_result_generation = r_res_gen;
    assign o_handle_ok         = r_res_ok;
    assign o_status            = r_res_status;

endmodule

>>> rtl/generational_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// Generational handle allocator core
// Allocates, frees and checks slot/generation handles over a FIFO free list.
// ----------------------------------------------------------------------------
//  channel  dir  port   words
//  request  in   i_in   opcode, handle_index, handle_generation
//  result   out  o_out  result_index, result_generation, handle_ok, status
//
//  Each word is accepted in S_IDLE, then runs in S_EXEC on the registered
//  reads of the generation and link tables. A free onto a nonempty list adds
//  an S_LINK step for the second write to the link table (old tail).
//  Reset clears only the list pointers, table size and result valid; no clearing pass.
//  The result register holds while o_out stalls; a new word is accepted only
//  in S_IDLE once that register is empty or drains in the same cycle.
// ----------------------------------------------------------------------------
`include "generational_handle_allocator_core_defines.svh"

module generational_handle_allocator_core #(
    parameter int SLOT_COUNT      = gha_pkg::SLOT_COUNT_DEF,
    parameter int GENERATION_BITS = gha_pkg::GENERATION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gha_in_if.sink            i_in,
    gha_out_if.source         o_out
);

    gha_pkg::t_cmd  w_cmd;
    gha_pkg::t_stat w_stat;
    logic           w_in_ready;

    gha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    gha_datapath #(
        .SLOT_COUNT      (SLOT_COUNT),
        .GENERATION_BITS (GENERATION_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_opcode            (i_in.opcode),
        .i_handle_index      (i_in.handle_index),
        .i_handle_generation (i_in.handle_generation),
        .i_out_ready         (o_out.ready),
        .o_out_valid         (o_out.valid),
        .o_result_index      (o_out.result_index),
        .o_result_generation (o_out.result_generation),
        .o_handle_ok         (o_out.handle_ok),
        .o_status            (o_out.status)
    );

    assign i_in.ready = w_in_ready;

    `GHA_ASSERT_IMPLY(a_accept_out_free, i_in.valid && i_in.ready, !o_out.valid || o_out.ready)
    `GHA_ASSERT_NEXT(a_accept_busy, i_in.valid && i_in.ready, !i_in.ready)
    `GHA_ASSERT_DELAY2(a_accept_result, i_in.valid && i_in.ready, o_out.valid)
    `GHA_ASSERT_IMPLY(a_execute_empty, w_cmd.execute, !o_out.valid)

endmodule
